// ===== rtl/ppvl_pkg.sv =====
// ppvl_pkg: constants, register and step codes, and state type of the planar position pd
// velocity limiter. Depends on nothing; used by planar_position_pd_velocity_limiter_core.
package ppvl_pkg;

	// fixed controller constants
	localparam int GAIN_DIVIDER    = 1000;
	localparam int TURN_LIMIT      = 100;
	localparam int FLOOR_SPEED     = 10;
	localparam int FLOOR_THRESHOLD = 20;
	localparam int PCT_FULL        = 100;
	localparam int ANG_FULL        = 3600;
	localparam int ANG_HALF        = 1800;
	localparam int VEL_MAX         = 4095;

	// field widths
	localparam int POS_W   = 24;
	localparam int ERR_W   = 25;
	localparam int DIFF_W  = 26;
	localparam int ANG_W   = 12;
	localparam int ANGD_W  = 13;
	localparam int TRAW_W  = 14;
	localparam int PCT_W   = 7;
	localparam int GAIN_W  = 12;
	localparam int VEL_W   = 13;

	// serial arithmetic unit widths
	localparam int MA_W    = 28;
	localparam int MB_W    = 12;
	localparam int PROD_W  = 40;
	localparam int DEN_W   = 28;
	localparam int REM_W   = 29;
	localparam int CNT_W   = 6;

	// port widths
	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_Y     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_TURN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_TURN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_LIMIT_X = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_LIMIT_Y = 3'd7;

	// sequencer step codes
	typedef logic [4:0] op_t;
	localparam op_t OP_X_PROP   = 5'd0;
	localparam op_t OP_X_DIFF   = 5'd1;
	localparam op_t OP_X_GDIV   = 5'd2;
	localparam op_t OP_X_PMUL   = 5'd3;
	localparam op_t OP_X_PDIV   = 5'd4;
	localparam op_t OP_Y_PROP   = 5'd5;
	localparam op_t OP_Y_DIFF   = 5'd6;
	localparam op_t OP_Y_GDIV   = 5'd7;
	localparam op_t OP_Y_PMUL   = 5'd8;
	localparam op_t OP_Y_PDIV   = 5'd9;
	localparam op_t OP_T_PROP   = 5'd10;
	localparam op_t OP_T_DIFF   = 5'd11;
	localparam op_t OP_T_GDIV   = 5'd12;
	localparam op_t OP_T_PMUL   = 5'd13;
	localparam op_t OP_T_PDIV   = 5'd14;
	localparam op_t OP_LX_MUL   = 5'd15;
	localparam op_t OP_LX_DIV   = 5'd16;
	localparam op_t OP_LY_MUL   = 5'd17;
	localparam op_t OP_LY_DIV   = 5'd18;
	localparam op_t OP_LT_MUL   = 5'd19;
	localparam op_t OP_LT_DIV   = 5'd20;
	localparam op_t OP_CMP_X    = 5'd21;
	localparam op_t OP_CMP_Y    = 5'd22;
	localparam op_t OP_SX_MUL   = 5'd23;
	localparam op_t OP_SX_DIV   = 5'd24;
	localparam op_t OP_SY_MUL   = 5'd25;
	localparam op_t OP_SY_DIV   = 5'd26;
	localparam op_t OP_LAST     = OP_SY_DIV;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_WB   = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

endpackage

// ===== rtl/planar_position_pd_velocity_limiter_core.sv =====
// planar_position_pd_velocity_limiter_core: pd position controller with shared x/y velocity limit.
// Depends on ppvl_pkg for constants, step codes and the state type.
//
// One item in, at most one item out. An item with tuser (enable) low is taken and gives
// nothing. An enabled item runs a fixed program of 27 steps on one shared serial unit:
// 16 multiplications at one multiplier bit per cycle, each with a load and a write-back
// state, and 11 divisions at one quotient bit per cycle; most of the program's time goes
// to the restoring divider. The finish state then loads the output register.
// The finish state waits while an older result still sits unread at the master
// side. Once the new result is loaded the next item is taken, even while that result
// waits; no new item is taken while an enabled one runs its program. Register writes are
// taken at any time and are expected only while the block is idle.
module planar_position_pd_velocity_limiter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// pos_x[23:0] pos_y[47:24] heading[59:48] goal_x[83:60] goal_y[107:84]
	// goal_heading[119:108] speed_percent[126:120], zero pad
	input  logic [ppvl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// enable
	input  logic                                s_axis_tuser,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// vel_x[12:0] vel_y[25:13] vel_turn[38:26], zero pad
	output logic [ppvl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ppvl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppvl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ppvl_pkg::*;

	// configuration registers
	logic [GAIN_W-1:0] gain_p_x_q, gain_d_x_q, gain_p_y_q, gain_d_y_q;
	logic [GAIN_W-1:0] gain_p_turn_q, gain_d_turn_q, base_limit_x_q, base_limit_y_q;

	// errors kept from the last enabled item
	logic signed [ERR_W-1:0] prev_err_x_q, prev_err_y_q;
	logic signed [ANG_W-1:0] prev_err_turn_q;

	// errors and differences of the item at work
	logic signed [ERR_W-1:0]  err_x_q, err_y_q;
	logic signed [DIFF_W-1:0] diff_x_q, diff_y_q;
	logic signed [ANG_W-1:0]  err_t_q;
	logic signed [ANGD_W-1:0] diff_t_q;
	logic [PCT_W-1:0]         pct_q;

	// working values
	logic [PROD_W-1:0] wk_q;
	logic [MA_W-1:0]   vmag_x_q, vmag_y_q, vmag_t_q, smag_x_q, smag_y_q;
	logic              vsgn_x_q, vsgn_y_q, vsgn_t_q;
	logic [GAIN_W-1:0] lim_x_q, lim_y_q, lim_t_q, mul_q;
	logic [DEN_W-1:0]  div_q;

	// serial unit
	logic [PROD_W-1:0] acc_q, ash_q, quo_q;
	logic [MB_W-1:0]   bsh_q;
	logic [REM_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [CNT_W-1:0]  cnt_q;

	op_t    op_q;
	state_t st_q;

	logic                 out_valid_q;
	logic [VEL_W-1:0]     vel_x_q, vel_y_q, vel_turn_q;

	// input fields
	logic signed [POS_W-1:0] in_pos_x, in_pos_y, in_goal_x, in_goal_y;
	logic [ANG_W-1:0]        in_heading, in_goal_heading;
	logic [PCT_W-1:0]        in_speed_percent;

	assign in_pos_x         = s_axis_tdata[23:0];
	assign in_pos_y         = s_axis_tdata[47:24];
	assign in_heading       = s_axis_tdata[59:48];
	assign in_goal_x        = s_axis_tdata[83:60];
	assign in_goal_y        = s_axis_tdata[107:84];
	assign in_goal_heading  = s_axis_tdata[119:108];
	assign in_speed_percent = s_axis_tdata[126:120];

	logic in_acc, cfg_acc, fin_load;
	assign s_axis_tready = (st_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign cfg_acc       = cfg_valid & cfg_ready;

	// errors at acceptance
	logic signed [ERR_W-1:0]  ex_w, ey_w;
	logic signed [DIFF_W-1:0] dx_w, dy_w;
	logic signed [TRAW_W-1:0] t_raw, t_mod;
	logic signed [ANG_W-1:0]  et_w;
	logic signed [ANGD_W-1:0] dt_w;
	logic [PCT_W-1:0]         pct_w;

	always_comb begin
		ex_w  = ERR_W'(in_goal_x) - ERR_W'(in_pos_x);
		ey_w  = ERR_W'(in_goal_y) - ERR_W'(in_pos_y);
		dx_w  = DIFF_W'(ex_w) - DIFF_W'(prev_err_x_q);
		dy_w  = DIFF_W'(ey_w) - DIFF_W'(prev_err_y_q);
		// heading error wrapped by true modulo, one correction is enough
		t_raw = signed'(TRAW_W'(in_goal_heading)) - signed'(TRAW_W'(in_heading))
			+ TRAW_W'(ANG_HALF);
		if (t_raw < 0) begin
			t_mod = t_raw + TRAW_W'(ANG_FULL);
		end else if (t_raw >= TRAW_W'(ANG_FULL)) begin
			t_mod = t_raw - TRAW_W'(ANG_FULL);
		end else begin
			t_mod = t_raw;
		end
		et_w  = ANG_W'(t_mod - TRAW_W'(ANG_HALF));
		dt_w  = ANGD_W'(et_w) - ANGD_W'(prev_err_turn_q);
		pct_w = (in_speed_percent > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : in_speed_percent;
	end

	// magnitudes of the stored errors
	logic [ERR_W-1:0]  abs_ex, abs_ey;
	logic [DIFF_W-1:0] abs_dx, abs_dy;
	logic [ANG_W-1:0]  abs_et;
	logic [ANGD_W-1:0] abs_dt;

	assign abs_ex = err_x_q[ERR_W-1]   ? ERR_W'(-err_x_q)   : ERR_W'(err_x_q);
	assign abs_ey = err_y_q[ERR_W-1]   ? ERR_W'(-err_y_q)   : ERR_W'(err_y_q);
	assign abs_dx = diff_x_q[DIFF_W-1] ? DIFF_W'(-diff_x_q) : DIFF_W'(diff_x_q);
	assign abs_dy = diff_y_q[DIFF_W-1] ? DIFF_W'(-diff_y_q) : DIFF_W'(diff_y_q);
	assign abs_et = err_t_q[ANG_W-1]   ? ANG_W'(-err_t_q)   : ANG_W'(err_t_q);
	assign abs_dt = diff_t_q[ANGD_W-1] ? ANGD_W'(-diff_t_q) : ANGD_W'(diff_t_q);

	// step program: operands of the shared unit for each step
	logic              op_div;
	logic [PROD_W-1:0] opa;
	logic [DEN_W-1:0]  opb;
	logic              se, sd;

	always_comb begin
		op_div = 1'b0;
		opa    = '0;
		opb    = '0;
		se     = 1'b0;
		sd     = 1'b0;
		case (op_q)
			OP_X_PROP: begin opa = PROD_W'(abs_ex); opb = DEN_W'(gain_p_x_q); end
			OP_X_DIFF: begin
				opa = PROD_W'(abs_dx); opb = DEN_W'(gain_d_x_q);
				se  = err_x_q[ERR_W-1]; sd = diff_x_q[DIFF_W-1];
			end
			OP_Y_PROP: begin opa = PROD_W'(abs_ey); opb = DEN_W'(gain_p_y_q); end
			OP_Y_DIFF: begin
				opa = PROD_W'(abs_dy); opb = DEN_W'(gain_d_y_q);
				se  = err_y_q[ERR_W-1]; sd = diff_y_q[DIFF_W-1];
			end
			OP_T_PROP: begin opa = PROD_W'(abs_et); opb = DEN_W'(gain_p_turn_q); end
			OP_T_DIFF: begin
				opa = PROD_W'(abs_dt); opb = DEN_W'(gain_d_turn_q);
				se  = err_t_q[ANG_W-1]; sd = diff_t_q[ANGD_W-1];
			end
			OP_X_GDIV, OP_Y_GDIV, OP_T_GDIV: begin
				op_div = 1'b1; opa = wk_q; opb = DEN_W'(GAIN_DIVIDER);
			end
			OP_X_PMUL, OP_Y_PMUL, OP_T_PMUL: begin
				opa = PROD_W'(wk_q[MA_W-1:0]); opb = DEN_W'(pct_q);
			end
			OP_X_PDIV, OP_Y_PDIV, OP_T_PDIV, OP_LX_DIV, OP_LY_DIV, OP_LT_DIV: begin
				op_div = 1'b1; opa = wk_q; opb = DEN_W'(PCT_FULL);
			end
			OP_LX_MUL: begin opa = PROD_W'(base_limit_x_q); opb = DEN_W'(pct_q); end
			OP_LY_MUL: begin opa = PROD_W'(base_limit_y_q); opb = DEN_W'(pct_q); end
			OP_LT_MUL: begin opa = PROD_W'(TURN_LIMIT); opb = DEN_W'(pct_q); end
			OP_CMP_X:  begin opa = PROD_W'(vmag_y_q); opb = DEN_W'(lim_x_q); end
			OP_CMP_Y:  begin opa = PROD_W'(vmag_x_q); opb = DEN_W'(lim_y_q); end
			OP_SX_MUL: begin opa = PROD_W'(vmag_x_q); opb = DEN_W'(mul_q); end
			OP_SY_MUL: begin opa = PROD_W'(vmag_y_q); opb = DEN_W'(mul_q); end
			OP_SX_DIV, OP_SY_DIV: begin op_div = 1'b1; opa = wk_q; opb = div_q; end
			default: begin op_div = 1'b0; end
		endcase
	end

	// pd sum of the two products with their signs
	logic signed [PROD_W:0] pd_sum;
	logic [PROD_W-1:0]      pd_mag;
	always_comb begin
		pd_sum = (se ? -signed'((PROD_W+1)'(wk_q)) : signed'((PROD_W+1)'(wk_q)))
			+ (sd ? -signed'((PROD_W+1)'(acc_q)) : signed'((PROD_W+1)'(acc_q)));
		pd_mag = pd_sum[PROD_W] ? PROD_W'(-pd_sum) : PROD_W'(pd_sum);
	end

	// shared shrink ratio: lx*ay sits in wk_q, ly*ax in acc_q
	logic              over_x, over_y;
	logic [GAIN_W-1:0] mul_w;
	logic [DEN_W-1:0]  div_w;
	always_comb begin
		over_x = vmag_x_q > MA_W'(lim_x_q);
		over_y = vmag_y_q > MA_W'(lim_y_q);
		mul_w  = GAIN_W'(1);
		div_w  = DEN_W'(1);
		if (over_x && over_y) begin
			if (wk_q > acc_q) begin
				mul_w = lim_y_q; div_w = vmag_y_q;
			end else begin
				mul_w = lim_x_q; div_w = vmag_x_q;
			end
		end else if (over_x) begin
			mul_w = lim_x_q; div_w = vmag_x_q;
		end else if (over_y) begin
			mul_w = lim_y_q; div_w = vmag_y_q;
		end
	end

	// divider trial subtraction
	logic [REM_W-1:0] rem_sh;
	logic [REM_W:0]   trial;
	assign rem_sh = {rem_q[REM_W-2:0], quo_q[PROD_W-1]};
	assign trial  = {1'b0, rem_sh} - (REM_W+1)'(den_q);

	logic [PROD_W-1:0] res;
	assign res = op_div ? quo_q : acc_q;

	// the derivative steps write back the magnitude of the pd sum instead of the product, and its sign
	logic wb_pd;
	assign wb_pd = (op_q == OP_X_DIFF) || (op_q == OP_Y_DIFF) || (op_q == OP_T_DIFF);

	// floor speed and clamps
	logic [MA_W-1:0]   fx, fy, cx, cy, ct;
	logic [VEL_W-1:0]  vx_w, vy_w, vt_w;
	always_comb begin
		fx = ((smag_x_q < MA_W'(FLOOR_SPEED)) && (vmag_x_q != '0)
			&& (abs_ex > ERR_W'(FLOOR_THRESHOLD))) ? MA_W'(FLOOR_SPEED) : smag_x_q;
		fy = ((smag_y_q < MA_W'(FLOOR_SPEED)) && (vmag_y_q != '0)
			&& (abs_ey > ERR_W'(FLOOR_THRESHOLD))) ? MA_W'(FLOOR_SPEED) : smag_y_q;
		cx = (fx > MA_W'(lim_x_q)) ? MA_W'(lim_x_q) : fx;
		cy = (fy > MA_W'(lim_y_q)) ? MA_W'(lim_y_q) : fy;
		ct = (vmag_t_q > MA_W'(lim_t_q)) ? MA_W'(lim_t_q) : vmag_t_q;
		if (cx > MA_W'(VEL_MAX)) cx = MA_W'(VEL_MAX);
		if (cy > MA_W'(VEL_MAX)) cy = MA_W'(VEL_MAX);
		if (ct > MA_W'(VEL_MAX)) ct = MA_W'(VEL_MAX);
		vx_w = vsgn_x_q ? VEL_W'(-VEL_W'(cx)) : VEL_W'(cx);
		vy_w = vsgn_y_q ? VEL_W'(-VEL_W'(cy)) : VEL_W'(cy);
		vt_w = vsgn_t_q ? VEL_W'(-VEL_W'(ct)) : VEL_W'(ct);
	end

	assign fin_load = (st_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_x_q     <= '0;
			gain_d_x_q     <= '0;
			gain_p_y_q     <= '0;
			gain_d_y_q     <= '0;
			gain_p_turn_q  <= '0;
			gain_d_turn_q  <= '0;
			base_limit_x_q <= GAIN_W'(PCT_FULL);
			base_limit_y_q <= GAIN_W'(PCT_FULL);
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_GAIN_P_X:     gain_p_x_q     <= cfg_data;
				REG_GAIN_D_X:     gain_d_x_q     <= cfg_data;
				REG_GAIN_P_Y:     gain_p_y_q     <= cfg_data;
				REG_GAIN_D_Y:     gain_d_y_q     <= cfg_data;
				REG_GAIN_P_TURN:  gain_p_turn_q  <= cfg_data;
				REG_GAIN_D_TURN:  gain_d_turn_q  <= cfg_data;
				REG_BASE_LIMIT_X: base_limit_x_q <= cfg_data;
				REG_BASE_LIMIT_Y: base_limit_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stored errors, kept across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_x_q    <= '0;
			prev_err_y_q    <= '0;
			prev_err_turn_q <= '0;
		end else if (in_acc && s_axis_tuser) begin
			prev_err_x_q    <= ex_w;
			prev_err_y_q    <= ey_w;
			prev_err_turn_q <= et_w;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			op_q <= OP_X_PROP;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_acc && s_axis_tuser) begin
						op_q <= OP_X_PROP;
						st_q <= ST_LOAD;
					end
				end
				ST_LOAD: st_q <= op_div ? ST_DIV : ST_MUL;
				ST_MUL:  if (cnt_q == CNT_W'(MB_W - 1)) st_q <= ST_WB;
				ST_DIV:  if (cnt_q == CNT_W'(PROD_W - 1)) st_q <= ST_WB;
				ST_WB: begin
					if (op_q == OP_LAST) begin
						st_q <= ST_FIN;
					end else begin
						op_q <= op_q + op_t'(1);
						st_q <= ST_LOAD;
					end
				end
				ST_FIN:  if (fin_load) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// operand capture, serial unit and write-back
	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser) begin
			err_x_q  <= ex_w;
			err_y_q  <= ey_w;
			err_t_q  <= et_w;
			diff_x_q <= dx_w;
			diff_y_q <= dy_w;
			diff_t_q <= dt_w;
			pct_q    <= pct_w;
		end
		case (st_q)
			ST_LOAD: begin
				cnt_q <= '0;
				acc_q <= '0;
				ash_q <= opa;
				bsh_q <= opb[MB_W-1:0];
				rem_q <= '0;
				quo_q <= opa;
				den_q <= opb;
			end
			ST_MUL: begin
				// one multiplier bit per cycle, lsb first
				if (bsh_q[0]) acc_q <= acc_q + ash_q;
				ash_q <= {ash_q[PROD_W-2:0], 1'b0};
				bsh_q <= {1'b0, bsh_q[MB_W-1:1]};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_DIV: begin
				// restoring division, one quotient bit per cycle
				if (!trial[REM_W]) begin
					rem_q <= trial[REM_W-1:0];
					quo_q <= {quo_q[PROD_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[PROD_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_WB: begin
				wk_q <= wb_pd ? pd_mag : res;
				case (op_q)
					OP_X_DIFF: vsgn_x_q <= pd_sum[PROD_W];
					OP_Y_DIFF: vsgn_y_q <= pd_sum[PROD_W];
					OP_T_DIFF: vsgn_t_q <= pd_sum[PROD_W];
					OP_X_PDIV: vmag_x_q <= res[MA_W-1:0];
					OP_Y_PDIV: vmag_y_q <= res[MA_W-1:0];
					OP_T_PDIV: vmag_t_q <= res[MA_W-1:0];
					OP_LX_DIV: lim_x_q  <= res[GAIN_W-1:0];
					OP_LY_DIV: lim_y_q  <= res[GAIN_W-1:0];
					OP_LT_DIV: lim_t_q  <= res[GAIN_W-1:0];
					OP_CMP_Y:  begin mul_q <= mul_w; div_q <= div_w; end
					OP_SX_DIV: smag_x_q <= res[MA_W-1:0];
					OP_SY_DIV: smag_y_q <= res[MA_W-1:0];
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			vel_x_q    <= vx_w;
			vel_y_q    <= vy_w;
			vel_turn_q <= vt_w;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, vel_turn_q, vel_y_q, vel_x_q};

`ifndef SYNTHESIS
	// a disabled item leaves the sequencer idle
	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !s_axis_tuser |=> st_q == ST_IDLE)
		else $error("disabled item started the sequencer");

	// the divider never sees a zero divisor
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> den_q != '0)
		else $error("division by zero in serial unit");

	// the step counter stays within the program
	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> op_q <= OP_LAST)
		else $error("step counter beyond program");

	// a result loaded into the output register never reads as -4096
	a_vel_range: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> vel_x_q != 13'h1000 && vel_y_q != 13'h1000 && vel_turn_q != 13'h1000)
		else $error("velocity out of saturation range");
`endif

endmodule
